// File: hw/rtl/ppc_pkg.sv
package ppc_pkg;

   localparam int MaxParticles = 1024;
   localparam int PosBits      = 16;
   localparam int AddrBits     = $clog2(MaxParticles);
   localparam int CountBits    = $clog2(MaxParticles + 1);
   localparam int OutCountBits = 11;
   localparam int VelBits      = 7;
   localparam int LifeBits     = 4;
   localparam int AgeBits      = 8;
   localparam int EntryBits    = 2 * PosBits + 2 * VelBits + LifeBits + AgeBits;
   localparam int Radius       = 500;
   localparam int NumDirs      = 12;

   // direction index that carries no centre offset (point query)
   localparam logic [3:0] DIR_POINT = 4'd12;

   localparam logic [1:0] KIND_SPAWN = 2'd0;
   localparam logic [1:0] KIND_TICK  = 2'd1;
   localparam logic [1:0] KIND_POINT = 2'd2;
   localparam logic [1:0] KIND_DIR   = 2'd3;

   localparam logic CSR_LEAK_X = 1'b0;
   localparam logic CSR_LEAK_Y = 1'b1;

   typedef struct packed {
      logic signed [PosBits-1:0] x;
      logic signed [PosBits-1:0] y;
      logic signed [VelBits-1:0] vx;
      logic signed [VelBits-1:0] vy;
      logic [LifeBits-1:0]       life;
      logic [AgeBits-1:0]        age;
   } entry_type;

   // controller to datapath commands
   typedef struct packed {
      logic                capture;   // latch query fields
      logic                rd_en;     // issue store read
      logic [AddrBits-1:0] rd_addr;
      logic                wr_en;
      logic [AddrBits-1:0] wr_addr;
      logic                wr_spawn;  // write a new particle, else (without wr_last) the moved entry
      logic                wr_last;   // write the last entry (swap)
      logic                hold_last; // latch read data as last entry
      logic                eval;      // evaluate read data
      logic                clr_cnt;
      logic [3:0]          dir;       // direction index 0..11, or DIR_POINT
      logic                dir_done;  // compare count with best
   } ctl_cmd_type;

   typedef struct packed {
      logic expired;
   } dp_stat_type;

   function automatic logic signed [PosBits-1:0] sat_pos(input logic signed [PosBits+1:0] v);
      logic signed [PosBits+1:0] hi;
      logic signed [PosBits+1:0] lo;
      hi = (PosBits+2)'((64'sd1 <<< (PosBits - 1)) - 1);
      lo = -hi - 1;
      if (v > hi) return hi[PosBits-1:0];
      if (v < lo) return lo[PosBits-1:0];
      return v[PosBits-1:0];
   endfunction

   // centre offsets; any other index (point query) has none
   function automatic logic signed [10:0] dir_dx(input logic [3:0] d);
      case (d)
         4'd0: return 11'sd250;   4'd1: return 11'sd433;   4'd2: return 11'sd500;
         4'd3: return 11'sd433;   4'd4: return 11'sd250;   4'd5: return 11'sd0;
         4'd6: return -11'sd250;  4'd7: return -11'sd433;  4'd8: return -11'sd500;
         4'd9: return -11'sd433;  4'd10: return -11'sd250; 4'd11: return 11'sd0;
         default: return 11'sd0;
      endcase
   endfunction

   function automatic logic signed [10:0] dir_dy(input logic [3:0] d);
      case (d)
         4'd0: return 11'sd433;   4'd1: return 11'sd250;   4'd2: return 11'sd0;
         4'd3: return -11'sd250;  4'd4: return -11'sd433;  4'd5: return -11'sd500;
         4'd6: return -11'sd433;  4'd7: return -11'sd250;  4'd8: return 11'sd0;
         4'd9: return 11'sd250;   4'd10: return 11'sd433;  4'd11: return 11'sd500;
         default: return 11'sd0;
      endcase
   endfunction

endpackage

// File: hw/rtl/ppc_if.sv
interface ppc_req_if;
   import ppc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [1:0]                kind;
   logic signed [VelBits-1:0] vel_x;
   logic signed [VelBits-1:0] vel_y;
   logic [LifeBits-1:0]       lifetime;
   logic signed [15:0]        query_x;
   logic signed [15:0]        query_y;
   modport source (output valid, kind, vel_x, vel_y, lifetime, query_x, query_y, input ready);
   modport sink (input valid, kind, vel_x, vel_y, lifetime, query_x, query_y, output ready);
endinterface

interface ppc_rsp_if;
   import ppc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [OutCountBits-1:0] hit_count;
   logic [3:0]              best_direction;
   logic                    spawn_dropped;
   logic [OutCountBits-1:0] live_count;
   modport source (output valid, hit_count, best_direction, spawn_dropped, live_count,
                   input ready);
   modport sink (input valid, hit_count, best_direction, spawn_dropped, live_count,
                 output ready);
endinterface

// File: hw/rtl/ppc_ram.sv
module ppc_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem_ff[rd_addr];
   end
endmodule

// File: hw/rtl/ppc_datapath.sv
module ppc_datapath
   import ppc_pkg::*;
(
   input  logic                      clock,
   input  ctl_cmd_type               cmd,
   input  logic signed [15:0]        leak_x,
   input  logic signed [15:0]        leak_y,
   input  logic signed [VelBits-1:0] vel_x,
   input  logic signed [VelBits-1:0] vel_y,
   input  logic [LifeBits-1:0]       lifetime,
   input  logic signed [15:0]        query_x,
   input  logic signed [15:0]        query_y,
   input  logic                      reset,
   output dp_stat_type               stat,
   output logic [CountBits-1:0]      hit_count,
   output logic [3:0]                best_dir
);
   logic signed [15:0] qx_ff, qy_ff;
   logic [EntryBits-1:0] rd_data, wr_data;
   entry_type rd_entry, moved, last_ff, spawn_e;
   logic signed [PosBits+1:0] cx, cy, dx, dy;
   logic signed [PosBits+1:0] adx, ady;
   logic near_ff, near_in, eval_ff;
   logic [CountBits-1:0] cnt_ff, best_cnt_ff;
   logic [3:0] best_ff;
   logic [AgeBits-1:0] age_next;
   logic [8:0] radius_sq_lo;
   logic [19:0] sq_x_ff, sq_y_ff;

   assign rd_entry = entry_type'(rd_data);

   // move and age the entry just read
   always_comb begin
      moved = rd_entry;
      moved.x = sat_pos((PosBits+2)'(rd_entry.x) + (PosBits+2)'(rd_entry.vx));
      moved.y = sat_pos((PosBits+2)'(rd_entry.y) + (PosBits+2)'(rd_entry.vy));
      age_next = rd_entry.age + 1'b1;
      moved.age = age_next;
   end
   assign stat.expired = {1'b0, age_next} > ({5'd0, rd_entry.life} * 9'd10);

   always_comb begin
      spawn_e.x = sat_pos((PosBits+2)'(leak_x));
      spawn_e.y = sat_pos((PosBits+2)'(leak_y));
      spawn_e.vx = vel_x;
      spawn_e.vy = vel_y;
      spawn_e.life = lifetime;
      spawn_e.age = '0;
   end

   always_comb begin
      if (cmd.wr_spawn) wr_data = EntryBits'(spawn_e);
      else if (cmd.wr_last) wr_data = EntryBits'(last_ff);
      else wr_data = EntryBits'(moved);
   end

   ppc_ram #(.Width(EntryBits), .Depth(MaxParticles)) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (cmd.wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_data)
   );

   // distance test: register squares, then compare
   assign cx = (PosBits+2)'(qx_ff) + (PosBits+2)'(dir_dx(cmd.dir));
   assign cy = (PosBits+2)'(qy_ff) + (PosBits+2)'(dir_dy(cmd.dir));
   assign dx = (PosBits+2)'(rd_entry.x) - cx;
   assign dy = (PosBits+2)'(rd_entry.y) - cy;
   assign adx = dx < 0 ? -dx : dx;
   assign ady = dy < 0 ? -dy : dy;
   assign radius_sq_lo = 9'(Radius);
   assign near_in = (adx < (PosBits+2)'(Radius)) && (ady < (PosBits+2)'(Radius));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         qx_ff <= query_x;
         qy_ff <= query_y;
      end
      if (cmd.hold_last) last_ff <= rd_entry;
      eval_ff <= cmd.eval & near_in;
      near_ff <= near_in;
      sq_x_ff <= 20'(adx[8:0] * adx[8:0]);
      sq_y_ff <= 20'(ady[8:0] * ady[8:0]);
      if (cmd.clr_cnt) cnt_ff <= '0;
      else if (eval_ff && near_ff &&
               (21'(sq_x_ff) + 21'(sq_y_ff) < 21'(radius_sq_lo) * 21'(radius_sq_lo)))
         cnt_ff <= cnt_ff + 1'b1;
      if (reset) begin
         best_ff <= 4'd1;
         best_cnt_ff <= '0;
      end else if (cmd.capture) begin
         best_ff <= 4'd1;
         best_cnt_ff <= '0;
      end else if (cmd.dir_done && (cmd.dir == 4'd0 || cnt_ff > best_cnt_ff)) begin
         best_ff <= cmd.dir + 4'd1;
         best_cnt_ff <= cnt_ff;
      end
   end

   assign hit_count = best_cnt_ff;
   assign best_dir = best_ff;
endmodule

// File: hw/rtl/ppc_ctrl.sv
module ppc_ctrl
   import ppc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           kind,
   input  dp_stat_type          stat,
   output ctl_cmd_type          cmd,
   output logic                 busy,
   output logic                 done,
   output logic                 dropped,
   output logic [CountBits-1:0] total
);
   typedef enum logic [3:0] {
      S_IDLE, S_T_RD, S_T_CHK, S_T_LAST, S_T_SWAP, S_Q_RD, S_Q_DRAIN, S_Q_END, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [CountBits-1:0] k_ff, k_in, total_ff, total_in;
   logic [3:0] dir_ff, dir_in;
   logic [2:0] drain_ff, drain_in;
   logic [1:0] kind_ff, kind_in;
   logic dropped_ff, dropped_in;
   logic [CountBits-1:0] last_idx;

   assign last_idx = total_ff - 1'b1;

   always_comb begin
      state_in = state_ff;
      k_in = k_ff;
      total_in = total_ff;
      dir_in = dir_ff;
      drain_in = drain_ff;
      kind_in = kind_ff;
      dropped_in = dropped_ff;
      cmd = '0;
      cmd.dir = dir_ff;
      cmd.rd_addr = k_ff[AddrBits-1:0];
      cmd.wr_addr = k_ff[AddrBits-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in = kind;
               k_in = '0;
               dir_in = '0;
               dropped_in = 1'b0;
               cmd.capture = 1'b1;
               cmd.clr_cnt = 1'b1;
               unique case (kind)
                  KIND_SPAWN: begin
                     if (total_ff >= CountBits'(MaxParticles)) dropped_in = 1'b1;
                     else begin
                        cmd.wr_en = 1'b1;
                        cmd.wr_spawn = 1'b1;
                        cmd.wr_addr = total_ff[AddrBits-1:0];
                        total_in = total_ff + 1'b1;
                     end
                     state_in = S_DONE;
                  end
                  KIND_TICK: state_in = S_T_RD;
                  default: begin
                     if (kind == KIND_POINT) dir_in = DIR_POINT; // zero offset
                     state_in = S_Q_RD;
                  end
               endcase
            end
         end
         // tick: read entry k, then move or replace it
         S_T_RD: begin
            if (k_ff >= total_ff) state_in = S_DONE;
            else begin
               cmd.rd_en = 1'b1;
               state_in = S_T_CHK;
            end
         end
         S_T_CHK: begin
            if (stat.expired) begin
               total_in = total_ff - 1'b1;
               cmd.rd_en = 1'b1;
               cmd.rd_addr = last_idx[AddrBits-1:0];
               state_in = S_T_LAST;
            end else begin
               cmd.wr_en = 1'b1;
               k_in = k_ff + 1'b1;
               state_in = S_T_RD;
            end
         end
         S_T_LAST: begin
            cmd.hold_last = 1'b1;
            state_in = S_T_SWAP;
         end
         S_T_SWAP: begin
            // write swapped entry back, then recheck it at the same index
            cmd.wr_en = 1'b1;
            cmd.wr_last = 1'b1;
            state_in = S_T_RD;
         end
         // query: stream every entry through the distance test
         S_Q_RD: begin
            if (k_ff != '0) cmd.eval = 1'b1;
            if (k_ff >= total_ff) begin
               drain_in = 3'd0;
               state_in = S_Q_DRAIN;
            end else begin
               cmd.rd_en = 1'b1;
               k_in = k_ff + 1'b1;
            end
         end
         S_Q_DRAIN: begin
            drain_in = drain_ff + 1'b1;
            if (drain_ff == 3'd2) state_in = S_Q_END;
         end
         S_Q_END: begin
            cmd.dir_done = 1'b1;
            cmd.clr_cnt = 1'b1;
            k_in = '0;
            if (kind_ff == KIND_DIR && dir_ff != 4'(NumDirs - 1)) begin
               dir_in = dir_ff + 1'b1;
               state_in = S_Q_RD;
            end else state_in = S_DONE;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= '0;
         dropped_ff <= 1'b0;
         dir_ff <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         dropped_ff <= dropped_in;
         dir_ff <= dir_in;
      end
      k_ff <= k_in;
      drain_ff <= drain_in;
      kind_ff <= kind_in;
   end

   assign busy = state_ff != S_IDLE;
   assign done = state_ff == S_DONE;
   assign dropped = dropped_ff;
   assign total = total_ff;

   a_total_range: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CountBits'(MaxParticles)) else $error("count overflow");
   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_T_CHK |-> k_ff < total_ff) else $error("tick index past end");
   a_dir_bound: assert property (@(posedge clock) disable iff (reset)
      dir_ff <= DIR_POINT) else $error("direction out of range");
endmodule

// File: hw/rtl/particle_plume_concentration.sv
// Gas plume particle store with concentration queries.
// req channel: one transaction per item (kind, spawn velocity and lifetime,
// query point). rsp channel: one transaction per item with hit_count,
// best_direction, spawn_dropped and live_count.
// csr port: index 0 writes leak_x, index 1 writes leak_y; write while idle.
// A spawn writes the store as it is accepted, unless it is full. A tick reads
// and checks each particle in turn; an expired one is replaced by the last
// entry, checked at the same index. A point query streams each live particle
// through the distance test, a direction query 12 such passes. The store has
// one read port. One item is in flight at a time; req_ready is low meanwhile.
// Reset clears the particle count and leak position; no clearing pass is
// needed since only entries below the count are read.
// The result sits in an output register; while the receiver stalls it is
// held, and the next item is accepted into work as soon as the register
// frees up.
module particle_plume_concentration
   import ppc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   ppc_req_if.sink       req,
   ppc_rsp_if.source     rsp,
   input  logic          csr_wr_en,
   input  logic          csr_index,
   input  logic [15:0]   csr_wr_data
);
   logic signed [15:0] leak_x_ff, leak_y_ff;
   ctl_cmd_type cmd;
   dp_stat_type stat;
   logic busy, done, dropped, start;
   logic [CountBits-1:0] total, hits;
   logic [3:0] best;
   logic [1:0] kind_ff;
   logic rsp_valid_ff;

   assign req.ready = !busy && !rsp_valid_ff;
   assign start = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         leak_x_ff <= '0;
         leak_y_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LEAK_X: leak_x_ff <= csr_wr_data;
            CSR_LEAK_Y: leak_y_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   ppc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .kind(req.kind), .stat(stat),
      .cmd(cmd), .busy(busy), .done(done), .dropped(dropped), .total(total)
   );

   ppc_datapath u_dp (
      .clock(clock), .cmd(cmd), .leak_x(leak_x_ff), .leak_y(leak_y_ff),
      .vel_x(req.vel_x), .vel_y(req.vel_y), .lifetime(req.lifetime),
      .query_x(req.query_x), .query_y(req.query_y), .reset(reset),
      .stat(stat), .hit_count(hits), .best_dir(best)
   );

   // load the output register when the item finishes, hold until taken
   always_ff @(posedge clock) begin
      if (start) kind_ff <= req.kind;
      if (reset) rsp_valid_ff <= 1'b0;
      else if (done) rsp_valid_ff <= 1'b1;
      else if (rsp.ready) rsp_valid_ff <= 1'b0;
      if (done) begin
         rsp.hit_count <= (kind_ff == KIND_POINT || kind_ff == KIND_DIR) ?
                          OutCountBits'(hits) : '0;
         rsp.best_direction <= (kind_ff == KIND_DIR) ? best : 4'd1;
         rsp.spawn_dropped <= dropped;
         rsp.live_count <= OutCountBits'(total);
      end
   end
   assign rsp.valid = rsp_valid_ff;
endmodule

// File: tb/sv/particle_plume_concentration_test.sv
`timescale 1ns / 100ps

module particle_plume_concentration_test;
   import ppc_pkg::*;

   localparam int StoreDepth   = 1024;
   localparam int WatchdogMax  = 100000;
   localparam int SettleCycles = 20;

   typedef struct {
      logic [OutCountBits-1:0] hit_count;
      logic [3:0]              best_direction;
      logic                    spawn_dropped;
      logic [OutCountBits-1:0] live_count;
   } plume_result_t;

   // centre offsets for direction indices 0 to 11 (hours of a clock face), in decimetres
   const int centre_dx[12] = '{250, 433, 500, 433, 250, 0, -250, -433, -500, -433, -250, 0};
   const int centre_dy[12] = '{433, 250, 0, -250, -433, -500, -433, -250, 0, 250, 433, 500};

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_index;
   logic [15:0] csr_wr_data;

   ppc_req_if req ();
   ppc_rsp_if rsp ();

   particle_plume_concentration uut (
      .clock       (clock),
      .reset       (reset),
      .req         (req.sink),
      .rsp         (rsp.source),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // shadow copy of the particle store
   logic signed [15:0] plume_x    [StoreDepth];
   logic signed [15:0] plume_y    [StoreDepth];
   logic signed [6:0]  plume_vx   [StoreDepth];
   logic signed [6:0]  plume_vy   [StoreDepth];
   logic [3:0]         plume_life [StoreDepth];
   logic [7:0]         plume_age  [StoreDepth];
   int                 plume_live;
   logic signed [15:0] leak_x_q;
   logic signed [15:0] leak_y_q;

   plume_result_t expected_results[$];

   int  mismatch_count;
   int  result_count;
   int  idle_cycles;
   int  kind_count[4];
   int  dropped_count;
   int  peak_live;
   bit  no_idle;
   bit  timed_out;

   always #5 clock = ~clock;

   function automatic logic signed [15:0] clamp_pos(input int v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[15:0];
   endfunction

   function automatic int count_in_disc(input int cx, input int cy);
      int n;
      int dx;
      int dy;
      n = 0;
      for (int k = 0; k < plume_live; k++) begin
         dx = int'(plume_x[k]) - cx;
         dy = int'(plume_y[k]) - cy;
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         if (dx < Radius && dy < Radius && dx * dx + dy * dy < Radius * Radius) n++;
      end
      return n;
   endfunction

   // move, age and cull; a particle swapped in is handled at the same slot
   function automatic void advance_plume();
      int k;
      int last;
      k = 0;
      while (k < plume_live) begin
         plume_x[k] = clamp_pos(int'(plume_x[k]) + int'(plume_vx[k]));
         plume_y[k] = clamp_pos(int'(plume_y[k]) + int'(plume_vy[k]));
         plume_age[k] = plume_age[k] + 8'd1;
         if (int'(plume_age[k]) > int'(plume_life[k]) * 10) begin
            last = plume_live - 1;
            plume_x[k]    = plume_x[last];
            plume_y[k]    = plume_y[last];
            plume_vx[k]   = plume_vx[last];
            plume_vy[k]   = plume_vy[last];
            plume_life[k] = plume_life[last];
            plume_age[k]  = plume_age[last];
            plume_live    = last;
         end else begin
            k++;
         end
      end
   endfunction

   function automatic plume_result_t predict_plume(input logic [1:0] kind,
         input logic signed [6:0] vx, input logic signed [6:0] vy, input logic [3:0] life,
         input logic signed [15:0] qx, input logic signed [15:0] qy);
      plume_result_t r;
      int n;
      int hits;
      hits = 0;
      r.best_direction = 4'd1;
      r.spawn_dropped = 1'b0;
      case (kind)
         KIND_SPAWN: begin
            if (plume_live >= StoreDepth) begin
               r.spawn_dropped = 1'b1;
            end else begin
               plume_x[plume_live]    = leak_x_q;
               plume_y[plume_live]    = leak_y_q;
               plume_vx[plume_live]   = vx;
               plume_vy[plume_live]   = vy;
               plume_life[plume_live] = life;
               plume_age[plume_live]  = 8'd0;
               plume_live++;
            end
         end
         KIND_TICK: advance_plume();
         KIND_POINT: hits = count_in_disc(int'(qx), int'(qy));
         default: begin
            for (int d = 0; d < NumDirs; d++) begin
               n = count_in_disc(int'(qx) + centre_dx[d], int'(qy) + centre_dy[d]);
               if (d == 0 || n > hits) begin
                  hits = n;
                  r.best_direction = 4'(d + 1);
               end
            end
         end
      endcase
      r.hit_count = OutCountBits'(hits);
      r.live_count = OutCountBits'(plume_live);
      return r;
   endfunction

   // send one transaction; valid stays high between back-to-back items
   task automatic send_item(input logic [1:0] kind, input int vx, input int vy,
         input int life, input int qx, input int qy);
      int gap;
      if (!no_idle && $urandom_range(99) < 26) begin
         gap = $urandom_range(6, 1);
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid    <= 1'b1;
      req.kind     <= kind;
      req.vel_x    <= 7'(vx);
      req.vel_y    <= 7'(vy);
      req.lifetime <= 4'(life);
      req.query_x  <= 16'(qx);
      req.query_y  <= 16'(qy);
      do @(posedge clock); while (!req.ready);
      expected_results.push_back(predict_plume(kind, 7'(vx), 7'(vy), 4'(life),
                                               16'(qx), 16'(qy)));
      kind_count[kind]++;
      if (plume_live > peak_live) peak_live = plume_live;
   endtask

   // hold off until every result has arrived
   task automatic drain_results();
      req.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_leak(input int x, input int y);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_LEAK_X;
      csr_wr_data <= 16'(x);
      @(posedge clock);
      csr_index   <= CSR_LEAK_Y;
      csr_wr_data <= 16'(y);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      leak_x_q = 16'(x);
      leak_y_q = 16'(y);
      @(posedge clock);
   endtask

   task automatic random_vel(output int v);
      v = int'($urandom_range(100)) - 50;
   endtask

   // directed: field extremes, every kind, zero lifetime and the swap re-check
   task automatic test_directed();
      write_leak(0, 0);
      send_item(KIND_TICK, 0, 0, 0, 0, 0);
      send_item(KIND_POINT, 0, 0, 0, 0, 0);
      send_item(KIND_DIR, 0, 0, 0, -32768, 32767);
      send_item(KIND_SPAWN, -50, 50, 0, 0, 0);
      send_item(KIND_SPAWN, 50, -50, 0, 0, 0);
      send_item(KIND_SPAWN, 0, 0, 15, 0, 0);
      send_item(KIND_SPAWN, 49, -49, 1, 0, 0);
      send_item(KIND_POINT, 0, 0, 0, 499, 0);
      send_item(KIND_POINT, 0, 0, 0, 500, 0);
      send_item(KIND_POINT, 0, 0, 0, 300, 400);
      send_item(KIND_TICK, 0, 0, 0, 0, 0);
      send_item(KIND_DIR, 0, 0, 0, -250, -433);
      send_item(KIND_DIR, 0, 0, 0, 500, 0);
      send_item(KIND_DIR, 0, 0, 0, 0, 500);
      write_leak(32767, -32768);
      send_item(KIND_SPAWN, 50, -50, 15, 0, 0);
      send_item(KIND_SPAWN, -50, 50, 15, 0, 0);
      send_item(KIND_TICK, 0, 0, 0, 0, 0);
      send_item(KIND_POINT, 0, 0, 0, 32767, -32768);
      send_item(KIND_DIR, 0, 0, 0, 32767, 32767);
      send_item(KIND_DIR, 0, 0, 0, -32768, -32768);
      for (int i = 0; i < 12; i++) send_item(KIND_TICK, 0, 0, 0, 0, 0);
   endtask

   // fill the store, overflow it, query it full, then expire everything
   task automatic test_full_store();
      write_leak(-32768, 32767);
      while (plume_live < StoreDepth) send_item(KIND_SPAWN, 0, 0, 0, 0, 0);
      send_item(KIND_SPAWN, 50, 50, 15, 0, 0);
      send_item(KIND_SPAWN, -50, -50, 7, 0, 0);
      send_item(KIND_POINT, 0, 0, 0, -32768, 32767);
      send_item(KIND_DIR, 0, 0, 0, -32768 - 250, 32767 - 433);
      send_item(KIND_TICK, 0, 0, 0, 0, 0);
      send_item(KIND_SPAWN, 1, 1, 1, 0, 0);
   endtask

   task automatic random_item(input int lx, input int ly);
      int r;
      int vx;
      int vy;
      int qx;
      int qy;
      r = $urandom_range(99);
      random_vel(vx);
      random_vel(vy);
      if ($urandom_range(9) < 7) begin
         qx = lx + int'($urandom_range(1400)) - 700;
         qy = ly + int'($urandom_range(1400)) - 700;
      end else begin
         qx = int'($urandom_range(65535)) - 32768;
         qy = int'($urandom_range(65535)) - 32768;
      end
      if (r < 40) send_item(KIND_SPAWN, vx, vy, $urandom_range(15), 0, 0);
      else if (r < 65) send_item(KIND_TICK, vx, vy, $urandom_range(15), qx, qy);
      else if (r < 85) send_item(KIND_POINT, vx, vy, $urandom_range(15), qx, qy);
      else send_item(KIND_DIR, vx, vy, $urandom_range(15), qx, qy);
   endtask

   // random traffic under four leak settings, one stretch without idling
   task automatic test_random();
      int lx;
      int ly;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin lx = 0; ly = 0; end
            1: begin lx = 32767; ly = 32767; end
            2: begin lx = -32768; ly = -32768; end
            default: begin
               lx = int'($urandom_range(65535)) - 32768;
               ly = int'($urandom_range(65535)) - 32768;
            end
         endcase
         write_leak(lx, ly);
         no_idle = (phase == 2);
         for (int i = 0; i < 120; i++) begin
            if (phase == 1 && i == 60) drain_results();
            random_item(lx, ly);
         end
         no_idle = 1'b0;
      end
   endtask

   // receiver stalls at random
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= no_idle || ($urandom_range(99) >= 26);
   end

   // compare each result with the oldest prediction
   always @(posedge clock) begin
      plume_result_t want;
      if (!reset && rsp.valid && rsp.ready) begin
         result_count++;
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result transaction");
         end else begin
            want = expected_results.pop_front();
            if (rsp.hit_count !== want.hit_count || rsp.best_direction !== want.best_direction ||
                rsp.spawn_dropped !== want.spawn_dropped || rsp.live_count !== want.live_count)
            begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected hit=%0d dir=%0d drop=%0d live=%0d, got %0d %0d %0d %0d",
                           want.hit_count, want.best_direction, want.spawn_dropped,
                           want.live_count, rsp.hit_count, rsp.best_direction,
                           rsp.spawn_dropped, rsp.live_count);
            end
            if (want.spawn_dropped) dropped_count++;
         end
      end
   end

   // watchdog on cycles with no transaction at all
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogMax) begin
         $display("watchdog expired with %0d results pending", expected_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_LEAK_X;
      csr_wr_data <= '0;
      req.valid <= 1'b0;
      req.kind <= KIND_SPAWN;
      req.vel_x <= '0;
      req.vel_y <= '0;
      req.lifetime <= '0;
      req.query_x <= '0;
      req.query_y <= '0;
      mismatch_count = 0;
      result_count = 0;
      idle_cycles = 0;
      dropped_count = 0;
      peak_live = 0;
      no_idle = 1'b0;
      plume_live = 0;
      leak_x_q = '0;
      leak_y_q = '0;
      for (int i = 0; i < 4; i++) kind_count[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_full_store();
      test_random();

      drain_results();
      repeat (SettleCycles) @(posedge clock);

      $display("covered %0d spawns (%0d dropped), %0d ticks, %0d point and %0d direction queries",
               kind_count[KIND_SPAWN], dropped_count, kind_count[KIND_TICK],
               kind_count[KIND_POINT], kind_count[KIND_DIR]);
      $display("peak store occupancy %0d, %0d results checked, %0d mismatches",
               peak_live, result_count, mismatch_count);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: particle_plume_concentration.f
hw/rtl/ppc_pkg.sv
hw/rtl/ppc_if.sv
hw/rtl/ppc_ram.sv
hw/rtl/ppc_datapath.sv
hw/rtl/ppc_ctrl.sv
hw/rtl/particle_plume_concentration.sv
tb/sv/particle_plume_concentration_test.sv
